FILE: src/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and constants for the track byte parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

	typedef enum logic [3:0] {
		PH_DELAY     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_DATA1     = 4'd2,
		PH_DATA2     = 4'd3,
		PH_META_TYPE = 4'd4,
		PH_LENGTH    = 4'd5,
		PH_PAYLOAD   = 4'd6
	} phase_t;

	localparam logic [2:0] KIND_DELAY   = 3'd0;
	localparam logic [2:0] KIND_CHANNEL = 3'd1;
	localparam logic [2:0] KIND_HEADER  = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic [7:0] STATUS_BIT     = 8'h80;
	localparam logic [7:0] OP_MASK        = 8'hF0;
	localparam logic [7:0] CHAN_MASK      = 8'h0F;
	localparam logic [7:0] OP_NOTE_OFF    = 8'h80;
	localparam logic [7:0] OP_NOTE_ON     = 8'h90;
	localparam logic [7:0] OP_PROGRAM     = 8'hC0;
	localparam logic [7:0] OP_PRESSURE    = 8'hD0;
	localparam logic [7:0] OP_SYSTEM      = 8'hF0;
	localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
	localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
	localparam logic [7:0] STATUS_META    = 8'hFF;
	localparam logic [7:0] META_TEMPO     = 8'h51;
	localparam logic [7:0] NOTE_OFF_VEL   = 8'h40;
	localparam logic [27:0] TEMPO_LEN     = 28'd3;
	localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  status_code;
		logic [3:0]  channel;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [27:0] count_value;
		logic [7:0]  payload_value;
		logic        payload_last;
		logic        tempo_changed;
		logic [23:0] tempo_value;
		logic        track_finished;
	} result_t;

endpackage

FILE: src/mtep_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Per-byte parse state and the combinational result for the current byte.
// ----------------------------------------------------------------------------
module mtep_parser #(
	parameter int VLQ_MAX_BYTES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              end_of_track,
	output mtep_pkg::result_t res,
	output logic              res_valid
);

	mtep_pkg::phase_t phase_q, phase_d;
	logic [7:0]  running_q, running_d;
	logic [7:0]  event_q, event_d;
	logic [7:0]  held_q, held_d;
	logic [27:0] acc_q, acc_d;
	logic [2:0]  vcnt_q, vcnt_d;
	logic [27:0] remain_q, remain_d;
	logic [23:0] tasm_q, tasm_d;
	logic [23:0] tempo_q, tempo_d;
	logic        error_q, error_d;

	function automatic logic one_data(input logic [7:0] st);
		logic [7:0] op;
		op = st & mtep_pkg::OP_MASK;
		return (op == mtep_pkg::OP_PROGRAM) || (op == mtep_pkg::OP_PRESSURE);
	endfunction

	always_comb begin
		logic [27:0] vacc;
		logic [2:0]  vcnt;
		logic        vcont;
		logic        vlong;
		logic        err;
		logic        clean;
		logic        have;
		logic        emit;
		logic [7:0]  est;
		logic [7:0]  ehold;
		logic [7:0]  esec;
		logic [7:0]  op;
		logic [27:0] rem;
		logic [23:0] tnew;

		phase_d   = phase_q;
		running_d = running_q;
		event_d   = event_q;
		held_d    = held_q;
		acc_d     = acc_q;
		vcnt_d    = vcnt_q;
		remain_d  = remain_q;
		tasm_d    = tasm_q;
		tempo_d   = tempo_q;
		error_d   = error_q;
		res       = '0;
		err       = 1'b0;
		clean     = 1'b0;
		have      = 1'b0;
		emit      = 1'b0;
		est       = event_q;
		ehold     = held_q;
		esec      = 8'h00;
		op        = 8'h00;

		vacc  = {acc_q[20:0], data_byte[6:0]};
		vcnt  = vcnt_q + 3'd1;
		vcont = data_byte[7];
		vlong = vcont && (vcnt >= 3'(VLQ_MAX_BYTES));
		rem   = remain_q - 28'd1;
		tnew  = {tasm_q[15:0], data_byte};

		case (phase_q)
			mtep_pkg::PH_DELAY: begin
				acc_d  = vacc;
				vcnt_d = vcnt;
				if (vlong) begin
					err = 1'b1;
				end else if (!vcont) begin
					res.result_kind = mtep_pkg::KIND_DELAY;
					res.count_value = vacc;
					have    = 1'b1;
					clean   = 1'b1;
					phase_d = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				if (data_byte[7]) begin
					if ((data_byte & mtep_pkg::OP_MASK) != mtep_pkg::OP_SYSTEM) begin
						running_d = data_byte;
						event_d   = data_byte;
						phase_d   = mtep_pkg::PH_DATA1;
					end else begin
						running_d = 8'h00;
						event_d   = data_byte;
						held_d    = 8'h00;
						if (data_byte == mtep_pkg::STATUS_META) begin
							phase_d = mtep_pkg::PH_META_TYPE;
						end else if (data_byte == mtep_pkg::STATUS_SYSEX ||
								data_byte == mtep_pkg::STATUS_ESCAPE) begin
							acc_d   = '0;
							vcnt_d  = '0;
							phase_d = mtep_pkg::PH_LENGTH;
						end else begin
							err = 1'b1;
						end
					end
				end else if (running_q != 8'h00) begin
					event_d = running_q;
					held_d  = data_byte;
					if (one_data(running_q)) begin
						emit  = 1'b1;
						est   = running_q;
						ehold = data_byte;
					end else begin
						phase_d = mtep_pkg::PH_DATA2;
					end
				end else begin
					err = 1'b1;
				end
			end
			mtep_pkg::PH_DATA1: begin
				held_d = data_byte;
				if (one_data(event_q)) begin
					emit  = 1'b1;
					ehold = data_byte;
				end else begin
					phase_d = mtep_pkg::PH_DATA2;
				end
			end
			mtep_pkg::PH_DATA2: begin
				emit = 1'b1;
				esec = data_byte;
			end
			mtep_pkg::PH_META_TYPE: begin
				held_d  = data_byte;
				acc_d   = '0;
				vcnt_d  = '0;
				phase_d = mtep_pkg::PH_LENGTH;
			end
			mtep_pkg::PH_LENGTH: begin
				acc_d  = vacc;
				vcnt_d = vcnt;
				if (vlong) begin
					err = 1'b1;
				end else if (!vcont) begin
					res.result_kind = mtep_pkg::KIND_HEADER;
					res.status_code = event_q;
					res.first_data  = held_q;
					res.count_value = vacc;
					have     = 1'b1;
					remain_d = vacc;
					tasm_d   = '0;
					if (vacc == 28'd0) begin
						phase_d = mtep_pkg::PH_DELAY;
						acc_d   = '0;
						vcnt_d  = '0;
						clean   = 1'b1;
					end else begin
						phase_d = mtep_pkg::PH_PAYLOAD;
					end
				end
			end
			mtep_pkg::PH_PAYLOAD: begin
				tasm_d   = tnew;
				remain_d = rem;
				res.result_kind   = mtep_pkg::KIND_PAYLOAD;
				res.status_code   = event_q;
				res.first_data    = held_q;
				res.payload_value = data_byte;
				have = 1'b1;
				if (rem == 28'd0) begin
					res.payload_last = 1'b1;
					if (event_q == mtep_pkg::STATUS_META && held_q == mtep_pkg::META_TEMPO &&
							acc_q == mtep_pkg::TEMPO_LEN && tnew != 24'd0 &&
							tnew != tempo_q) begin
						tempo_d           = tnew;
						res.tempo_changed = 1'b1;
					end
					phase_d = mtep_pkg::PH_DELAY;
					acc_d   = '0;
					vcnt_d  = '0;
					clean   = 1'b1;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase

		if (emit) begin
			op = est & mtep_pkg::OP_MASK;
			if (op == mtep_pkg::OP_NOTE_ON && esec == 8'h00) begin
				op   = mtep_pkg::OP_NOTE_OFF;
				esec = mtep_pkg::NOTE_OFF_VEL;
			end
			res.result_kind = mtep_pkg::KIND_CHANNEL;
			res.status_code = op;
			res.channel     = 4'(est & mtep_pkg::CHAN_MASK);
			res.first_data  = ehold;
			res.second_data = esec;
			have    = 1'b1;
			clean   = 1'b1;
			phase_d = mtep_pkg::PH_DELAY;
			acc_d   = '0;
			vcnt_d  = '0;
		end

		if (!err && end_of_track && !clean) begin
			err = 1'b1;
		end

		if (error_q || err) begin
			error_d         = 1'b1;
			tempo_d         = tempo_q;
			res             = '0;
			res.result_kind = mtep_pkg::KIND_ERROR;
			res.tempo_value = tempo_q;
			res_valid       = 1'b1;
		end else begin
			if (end_of_track) begin
				res.track_finished = 1'b1;
				phase_d   = mtep_pkg::PH_DELAY;
				running_d = 8'h00;
				acc_d     = '0;
				vcnt_d    = '0;
			end
			res.tempo_value = tempo_d;
			res_valid       = have;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mtep_pkg::PH_DELAY;
			running_q <= '0;
			event_q   <= '0;
			held_q    <= '0;
			acc_q     <= '0;
			vcnt_q    <= '0;
			remain_q  <= '0;
			tasm_q    <= '0;
			tempo_q   <= mtep_pkg::TEMPO_DEFAULT;
			error_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			running_q <= running_d;
			event_q   <= event_d;
			held_q    <= held_d;
			acc_q     <= acc_d;
			vcnt_q    <= vcnt_d;
			remain_q  <= remain_d;
			tasm_q    <= tasm_d;
			tempo_q   <= tempo_d;
			error_q   <= error_d;
		end
	end

endmodule

FILE: src/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses track bytes into delay, channel, sysex/meta header, payload and error results.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is registered in byte_s1, then its result is registered in res_q.
// Throughput: one track byte per cycle while the output is not stalled.
// A byte that completes nothing yields no output beat.
// Reset: asynchronous, active low; clears parse state, error, sets tempo 500000.
module midi_track_event_parser #(
	parameter int VLQ_MAX_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_track
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // [7:0] status_code, [11:8] channel,
	                                    // [19:12] first_data, [27:20] second_data,
	                                    // [55:28] count_value, [63:56] payload_value,
	                                    // [64] tempo_changed, [88:65] tempo_value,
	                                    // [89] track_finished, [95:90] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
	output logic        m_axis_tlast    // payload_last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eot_s1;
	logic              out_free;
	logic              step;
	logic              res_valid;
	mtep_pkg::result_t res;
	mtep_pkg::result_t res_q;
	logic              m_valid_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eot_s1  <= s_axis_tlast;
		end
	end

	mtep_parser #(
		.VLQ_MAX_BYTES(VLQ_MAX_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (byte_s1),
		.end_of_track(eot_s1),
		.res         (res),
		.res_valid   (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.result_kind;
	assign m_axis_tlast  = res_q.payload_last;
	assign m_axis_tdata  = {6'b000000, res_q.track_finished, res_q.tempo_value,
		res_q.tempo_changed, res_q.payload_value, res_q.count_value,
		res_q.second_data, res_q.first_data, res_q.channel, res_q.status_code};

`ifndef SYNTHESIS
	a_last_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == mtep_pkg::KIND_PAYLOAD)
		else $error("payload_last on a non-payload result");

	a_tempo_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.tempo_changed |-> m_axis_tlast)
		else $error("tempo change outside the final payload byte");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == mtep_pkg::KIND_ERROR |->
		m_axis_tdata[64:0] == 65'd0 && !m_axis_tdata[89])
		else $error("error result carries nonzero fields");
`endif

endmodule
